/* rtl/core/opmq_pkg.sv */
`default_nettype none

package opmq_pkg;

	localparam int DIST_W  = 12;
	localparam int COUNT_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIST_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [DIST_W-1:0]  PRESENT_THR_RST = 12'd80;
	localparam logic [DIST_W-1:0]  LOST_THR_RST    = 12'd192;
	localparam logic [DIST_W-1:0]  MOVE_THR_RST    = 12'd32;
	localparam logic [COUNT_W-1:0] CONFIRM_RST     = 8'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESENT_THR = 2'd0,
		REG_LOST_THR    = 2'd1,
		REG_MOVE_THR    = 2'd2,
		REG_CONFIRM     = 2'd3
	} opmq_reg_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              clear_state;
	} opmq_in_t;

	typedef struct packed {
		logic              object_present;
		logic              object_moved;
		logic [DIST_W-1:0] reference_distance;
	} opmq_out_t;

	typedef struct packed {
		logic [DIST_W-1:0]  present_threshold;
		logic [DIST_W-1:0]  lost_threshold;
		logic [DIST_W-1:0]  move_threshold;
		logic [COUNT_W-1:0] confirm_count;
	} opmq_cfg_t;

	typedef struct packed {
		logic               present_flag;
		logic               moved_flag;
		logic [DIST_W-1:0]  reference_value;
		logic [COUNT_W-1:0] near_count;
		logic [COUNT_W-1:0] gone_count;
		logic [COUNT_W-1:0] shift_count;
	} opmq_state_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/opmq_cfg.sv */
`default_nettype none

module opmq_cfg
	import opmq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output opmq_cfg_t                  cfg
);

	opmq_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.present_threshold <= PRESENT_THR_RST;
			cfg_q.lost_threshold    <= LOST_THR_RST;
			cfg_q.move_threshold    <= MOVE_THR_RST;
			cfg_q.confirm_count     <= CONFIRM_RST;
		end else if (cfg_we) begin
			unique case (opmq_reg_t'(cfg_index))
				REG_PRESENT_THR: cfg_q.present_threshold <= cfg_wdata[DIST_W-1:0];
				REG_LOST_THR:    cfg_q.lost_threshold    <= cfg_wdata[DIST_W-1:0];
				REG_MOVE_THR:    cfg_q.move_threshold    <= cfg_wdata[DIST_W-1:0];
				REG_CONFIRM:     cfg_q.confirm_count     <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/opmq_update.sv */
`default_nettype none

module opmq_update
	import opmq_pkg::*;
(
	input  wire opmq_state_t cur,
	input  wire opmq_cfg_t   cfg,
	input  wire opmq_in_t    sample,
	output opmq_state_t      nxt
);

	logic [DIST_W-1:0]  delta;
	logic [COUNT_W-1:0] near_inc;
	logic [COUNT_W-1:0] gone_inc;
	logic [COUNT_W-1:0] shift_inc;

	assign delta = (sample.distance >= cur.reference_value)
		? sample.distance - cur.reference_value
		: cur.reference_value - sample.distance;

	assign near_inc  = sat_inc(cur.near_count);
	assign gone_inc  = sat_inc(cur.gone_count);
	assign shift_inc = sat_inc(cur.shift_count);

	always_comb begin
		nxt = cur;
		if (sample.clear_state) begin
			nxt = '0;
		end else if (sample.distance == '0) begin
			// invalid reading: hold everything
			nxt = cur;
		end else if (!cur.present_flag) begin
			if (sample.distance <= cfg.present_threshold) begin
				if (near_inc >= cfg.confirm_count) begin
					nxt = '0;
					nxt.present_flag    = 1'b1;
					nxt.reference_value = sample.distance;
				end else begin
					nxt.near_count = near_inc;
				end
			end else begin
				nxt.near_count = '0;
			end
		end else if (sample.distance >= cfg.lost_threshold) begin
			if (gone_inc >= cfg.confirm_count) begin
				nxt = '0;
			end else begin
				nxt.gone_count = gone_inc;
			end
		end else begin
			nxt.gone_count = '0;
			if (cur.reference_value != '0) begin
				if (delta >= cfg.move_threshold) begin
					nxt.shift_count = shift_inc;
					if (shift_inc >= cfg.confirm_count) begin
						nxt.moved_flag = 1'b1;
					end
				end else begin
					nxt.shift_count = '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/object_presence_motion_qualifier.sv */
// Debounced presence and motion qualifier for distance samples in 1/16 cm.
// Each accepted sample produces exactly one result carrying the flags and the
// reference distance after that sample is applied. A sample is taken every
// cycle while the result side keeps up; each sample passes through the input
// register and then the result register, and the qualifier state (flags,
// reference and three saturating counters) is updated as the sample moves
// from the input register to the result register. A distance of zero without
// clear_state changes nothing but still yields a result. Write the threshold and
// confirm-count registers only while no transaction is in flight.
`default_nettype none

module object_presence_motion_qualifier
	import opmq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire opmq_in_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output opmq_out_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	opmq_cfg_t   cfg;
	opmq_state_t state_q;
	opmq_state_t state_nxt;
	opmq_in_t    sample_s1;
	logic        valid_s1;
	opmq_out_t   result_s2;
	logic        valid_s2;
	logic        advance;

	opmq_cfg_t u_cfg_unused_guard;
	assign u_cfg_unused_guard = cfg;

	opmq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	opmq_update u_update (
		.cur    (state_q),
		.cfg    (u_cfg_unused_guard),
		.sample (sample_s1),
		.nxt    (state_nxt)
	);

	// result register free or being drained
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2.object_present     <= state_nxt.present_flag;
			result_s2.object_moved       <= state_nxt.moved_flag;
			result_s2.reference_distance <= state_nxt.reference_value;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// moved is only ever reported together with presence
	a_moved_needs_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.object_moved || out_data.object_present))
		else $error("moved reported without presence");

	// a reference exists exactly while present
	a_ref_tracks_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.object_present == (out_data.reference_distance != '0)))
		else $error("reference and presence disagree");

	// while absent, only the near counter may run
	a_absent_counters: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.present_flag |-> (state_q.gone_count == '0 && state_q.shift_count == '0
			&& !state_q.moved_flag))
		else $error("stale counters while absent");

	// a stalled sample in the input register is kept
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(sample_s1)))
		else $error("input stage lost a sample");

endmodule

`default_nettype wire

/* test/tb_object_presence_motion_qualifier.sv */
`default_nettype none

module tb_object_presence_motion_qualifier;
	import opmq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTED = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	opmq_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	opmq_out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Qualifier state and register copies tracked by the testbench
	opmq_state_t qual_state;
	opmq_cfg_t qual_cfg;

	opmq_in_t pending_samples[$];
	opmq_out_t expected_reports[$];

	int unsigned samples_queued = 0;
	int unsigned samples_accepted = 0;
	int unsigned send_idle_pct = 7;
	int unsigned recv_idle_pct = 45;
	int unsigned hold_requests = 0;
	int unsigned holds_served;
	int unsigned hold_left;
	int unsigned quiet_cycles;
	int error_count = 0;

	object_presence_motion_qualifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
		return (c == '1) ? c : c + COUNT_W'(1);
	endfunction

	// Apply one accepted sample to the tracked state and queue the report it yields
	task automatic predict_report(input opmq_in_t smp);
		logic [DIST_W-1:0] d;
		logic [DIST_W-1:0] delta;
		opmq_out_t rpt;
		d = smp.distance;
		if (smp.clear_state) begin
			qual_state = '0;
		end else if (d != '0) begin
			if (!qual_state.present_flag) begin
				if (d <= qual_cfg.present_threshold) begin
					qual_state.near_count = count_up(qual_state.near_count);
					if (qual_state.near_count >= qual_cfg.confirm_count) begin
						qual_state = '0;
						qual_state.present_flag = 1'b1;
						qual_state.reference_value = d;
					end
				end else begin
					qual_state.near_count = '0;
				end
			end else if (d >= qual_cfg.lost_threshold) begin
				qual_state.gone_count = count_up(qual_state.gone_count);
				if (qual_state.gone_count >= qual_cfg.confirm_count)
					qual_state = '0;
			end else begin
				qual_state.gone_count = '0;
				if (qual_state.reference_value != '0) begin
					delta = (d >= qual_state.reference_value) ? d - qual_state.reference_value
						: qual_state.reference_value - d;
					if (delta >= qual_cfg.move_threshold) begin
						qual_state.shift_count = count_up(qual_state.shift_count);
						if (qual_state.shift_count >= qual_cfg.confirm_count)
							qual_state.moved_flag = 1'b1;
					end else begin
						qual_state.shift_count = '0;
					end
				end
			end
		end
		rpt.object_present = qual_state.present_flag;
		rpt.object_moved = qual_state.moved_flag;
		rpt.reference_distance = qual_state.reference_value;
		expected_reports.push_back(rpt);
	endtask

	task automatic check_report(input opmq_out_t got);
		opmq_out_t want;
		if (expected_reports.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected: present=%0b moved=%0b ref=%0d",
				got.object_present, got.object_moved, got.reference_distance));
		end else begin
			want = expected_reports.pop_front();
			if (got.object_present !== want.object_present)
				report_mismatch($sformatf("object_present got %0b want %0b",
					got.object_present, want.object_present));
			if (got.object_moved !== want.object_moved)
				report_mismatch($sformatf("object_moved got %0b want %0b",
					got.object_moved, want.object_moved));
			if (got.reference_distance !== want.reference_distance)
				report_mismatch($sformatf("reference_distance got %0d want %0d",
					got.reference_distance, want.reference_distance));
		end
	endtask

	// Sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_report(in_data);
				samples_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_samples.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and ready control
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			holds_served <= 0;
		end else begin
			if (out_valid && out_ready)
				check_report(out_data);
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served <= holds_served + 1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic push_sample(input logic [DIST_W-1:0] d, input logic clr);
		opmq_in_t smp;
		smp.distance = d;
		smp.clear_state = clr;
		pending_samples.push_back(smp);
		samples_queued++;
	endtask

	task automatic write_register(input opmq_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_PRESENT_THR: qual_cfg.present_threshold = val;
			REG_LOST_THR:    qual_cfg.lost_threshold = val;
			REG_MOVE_THR:    qual_cfg.move_threshold = val;
			REG_CONFIRM:     qual_cfg.confirm_count = val[COUNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_thresholds(input int unsigned pt, input int unsigned lt,
			input int unsigned mt, input int unsigned cc);
		write_register(REG_PRESENT_THR, CFG_DATA_W'(pt));
		write_register(REG_LOST_THR, CFG_DATA_W'(lt));
		write_register(REG_MOVE_THR, CFG_DATA_W'(mt));
		write_register(REG_CONFIRM, CFG_DATA_W'(cc));
	endtask

	// Hold until every queued sample is accepted and every report has arrived
	task automatic wait_drained();
		while (!(samples_accepted == samples_queued && expected_reports.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly runs that approach, move against and leave an object, with noise mixed in
	task automatic queue_traffic(input int unsigned count);
		int unsigned stop_at;
		int unsigned run;
		int unsigned kind;
		int unsigned cc;
		int unsigned off;
		int v;
		logic [DIST_W-1:0] anchor;
		anchor = 12'd1;
		stop_at = samples_queued + count;
		while (samples_queued < stop_at) begin
			kind = $urandom_range(99);
			cc = (qual_cfg.confirm_count == '0) ? 1 : qual_cfg.confirm_count;
			run = (kind < 80) ? cc - 1 + $urandom_range(2) : 1;
			if (run == 0)
				run = 1;
			for (int unsigned k = 0; k < run; k++) begin
				if (kind < 30) begin
					if (qual_cfg.present_threshold == '0 || $urandom_range(7) == 0) begin
						v = $urandom_range(4095, 1);
					end else begin
						if (k == 0 || $urandom_range(5) == 0)
							anchor = DIST_W'($urandom_range(qual_cfg.present_threshold, 1));
						v = anchor;
					end
					push_sample(DIST_W'(v), 1'b0);
				end else if (kind < 60) begin
					off = qual_cfg.move_threshold;
					if ($urandom_range(4) == 0)
						off = (off == 0) ? 0 : $urandom_range(off - 1);
					else
						off = off + $urandom_range(3);
					v = $urandom_range(1) ? int'(anchor) + int'(off) : int'(anchor) - int'(off);
					if (v < 1)
						v = 1;
					if (v > 4095)
						v = 4095;
					push_sample(DIST_W'(v), 1'b0);
				end else if (kind < 80) begin
					push_sample(DIST_W'($urandom_range(4095, qual_cfg.lost_threshold)), 1'b0);
				end else if (kind < 86) begin
					push_sample(DIST_W'($urandom_range(4095)), 1'b1);
				end else if (kind < 92) begin
					push_sample('0, 1'b0);
				end else begin
					push_sample(DIST_W'($urandom_range(4095)), 1'b0);
				end
			end
		end
	endtask

	initial begin
		qual_state = '0;
		qual_cfg.present_threshold = PRESENT_THR_RST;
		qual_cfg.lost_threshold = LOST_THR_RST;
		qual_cfg.move_threshold = MOVE_THR_RST;
		qual_cfg.confirm_count = CONFIRM_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: clear, invalid, confirm, move, lose, re-acquire at the bottom
		push_sample(12'hFFF, 1'b1);
		push_sample(12'd0, 1'b0);
		push_sample(12'd80, 1'b0);
		push_sample(12'd80, 1'b0);
		push_sample(12'd0, 1'b0);
		push_sample(12'd80, 1'b0);
		push_sample(12'd120, 1'b0);
		push_sample(12'd0, 1'b0);
		push_sample(12'd112, 1'b0);
		push_sample(12'd48, 1'b0);
		push_sample(12'd200, 1'b0);
		push_sample(12'd191, 1'b0);
		push_sample(12'd4095, 1'b0);
		push_sample(12'd192, 1'b0);
		push_sample(12'd4095, 1'b0);
		push_sample(12'd81, 1'b0);
		push_sample(12'd1, 1'b0);
		push_sample(12'd1, 1'b0);
		push_sample(12'd0, 1'b1);
		push_sample(12'd1, 1'b0);
		push_sample(12'd1, 1'b0);
		push_sample(12'd1, 1'b0);
		push_sample(12'd33, 1'b0);
		push_sample(12'd31, 1'b0);
		push_sample(12'd4095, 1'b0);
		push_sample(12'hAAA, 1'b0);
		push_sample(12'd4095, 1'b0);
		queue_traffic(300);
		wait_drained();

		// overlapping thresholds, zero move threshold, single-sample confirm
		set_thresholds(4095, 4095, 0, 1);
		queue_traffic(200);
		wait_drained();

		send_idle_pct <= 45;
		recv_idle_pct <= 7;
		// confirm count of zero acts like one
		set_thresholds(200, 300, 1, 0);
		queue_traffic(200);
		wait_drained();

		// longest confirm; counters run into saturation
		set_thresholds(2000, 2100, 100, 255);
		queue_traffic(400);
		wait_drained();

		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		set_thresholds(0, 0, 4095, 2);
		queue_traffic(60);
		wait_drained();

		set_thresholds($urandom_range(600, 16), $urandom_range(1000, 8),
			$urandom_range(200, 1), $urandom_range(6, 1));
		// stall the result side while samples keep coming
		hold_requests <= hold_requests + 1;
		queue_traffic(350);
		wait_drained();

		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
